[rtl/nmeah_pkg.sv]
// ----------------------------------------------------------------------------
// nmeah_pkg
// Shared types, constants and helpers for the NMEA checksum / baud hunter.
// ----------------------------------------------------------------------------
package nmeah_pkg;

  // special characters
  localparam logic [7:0] CharDollar = 8'h24;
  localparam logic [7:0] CharStar   = 8'h2A;
  localparam logic [7:0] CharSpace  = 8'h20;
  localparam logic [7:0] CharTab    = 8'h09;
  localparam logic [7:0] CharCr     = 8'h0D;

  // countdown and baud selection
  localparam int unsigned CntW = 12;
  localparam logic [CntW-1:0] CntReset        = 12'd600;
  localparam logic [CntW-1:0] FailReloadReset = 12'd30;
  localparam logic [CntW-1:0] OkReloadReset   = 12'd3000;
  localparam logic [2:0]      BaudReset       = 3'd3;
  localparam logic [2:0]      BaudFirst       = 3'd1;
  localparam logic [2:0]      BaudLast        = 3'd6;

  // configuration register indexes
  typedef enum logic {
    REG_FAIL_RELOAD = 1'b0,
    REG_OK_RELOAD   = 1'b1
  } reg_idx_e;

  // parser phase, one-hot
  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_BODY  = 4'b0010,
    PH_STAR  = 4'b0100,
    PH_DIGIT = 4'b1000
  } phase_e;

  // input transaction
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       has_byte;
    logic       chunk_end;
  } in_t;

  // result transaction
  typedef struct packed {
    logic        chunk_ok;
    logic        verdict_valid;
    logic [2:0]  baud_index;
    logic [16:0] line_rate;
    logic        baud_changed;
  } out_t;

  // reload values handed to the core
  typedef struct packed {
    logic [CntW-1:0] fail_reload;
    logic [CntW-1:0] ok_reload;
  } cfg_t;

  // hex digit test
  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  // hex digit value, only meaningful when is_hex holds
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    if (c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h61) begin
      v = c - 8'h57;
    end else begin
      v = c - 8'h37;
    end
    return v[3:0];
  endfunction

  // whitespace test: space, tab, lf, vt, ff, cr
  function automatic logic is_ws(input logic [7:0] c);
    return (c == CharSpace) || (c >= CharTab && c <= CharCr);
  endfunction

  // line rate in bits per second for a selection index
  function automatic logic [16:0] line_rate_of(input logic [2:0] idx);
    logic [16:0] r;
    case (idx)
      3'd1:    r = 17'd4800;
      3'd2:    r = 17'd9600;
      3'd3:    r = 17'd19200;
      3'd4:    r = 17'd38400;
      3'd5:    r = 17'd57600;
      3'd6:    r = 17'd115200;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

endpackage

[rtl/nmeah_core.sv]
// ----------------------------------------------------------------------------
// nmeah_core
// Sentence parser state, chunk countdown and baud selection. Computes the
// result of one input transaction and updates state when it is accepted.
// ----------------------------------------------------------------------------
module nmeah_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           take_i,
  input  nmeah_pkg::in_t in_i,
  input  nmeah_pkg::cfg_t cfg_i,
  output nmeah_pkg::out_t res_o
);
  import nmeah_pkg::*;

  phase_e          phase_q, phase_d;
  logic [7:0]      xor_q, xor_d;
  logic [3:0]      digit_q, digit_d;
  logic            seen_q, seen_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [2:0]      baud_q, baud_d;

  // byte stage values
  phase_e     ph1;
  logic [7:0] xor1;
  logic [3:0] dig1;
  logic       seen1;
  logic [7:0] c;
  logic       c_hex;
  logic [3:0] c_val;
  logic [CntW-1:0] cnt_dec;
  logic       ok;
  logic       changed;

  assign c     = in_i.rx_byte;
  assign c_hex = is_hex(c);
  assign c_val = hex_val(c);
  assign cnt_dec = cnt_q - 1'b1;

  // per-byte parser
  always_comb begin
    ph1   = phase_q;
    xor1  = xor_q;
    dig1  = digit_q;
    seen1 = seen_q;
    if (in_i.has_byte) begin
      unique case (phase_q)
        PH_IDLE: begin
          if (c == CharDollar) begin
            ph1  = PH_BODY;
            xor1 = 8'd0;
          end
        end
        PH_BODY: begin
          if (c == 8'd0) begin
            ph1 = PH_IDLE;
          end else if (c == CharDollar) begin
            xor1 = 8'd0;
          end else if (c == CharStar) begin
            ph1 = PH_STAR;
          end else begin
            xor1 = xor_q ^ c;
          end
        end
        PH_STAR: begin
          if (c_hex) begin
            dig1 = c_val;
            ph1  = PH_DIGIT;
          end else if (c == CharDollar) begin
            ph1  = PH_BODY;
            xor1 = 8'd0;
          end else if (!is_ws(c)) begin
            ph1 = PH_IDLE;
          end
        end
        PH_DIGIT: begin
          if (c_hex) begin
            if ({digit_q, c_val} == xor_q) seen1 = 1'b1;
            ph1 = PH_IDLE;
          end else begin
            if ({4'd0, digit_q} == xor_q) seen1 = 1'b1;
            if (c == CharDollar) begin
              ph1  = PH_BODY;
              xor1 = 8'd0;
            end else begin
              ph1 = PH_IDLE;
            end
          end
        end
        default: ph1 = PH_IDLE;
      endcase
    end
  end

  // chunk end: close sentence, update countdown and baud
  always_comb begin
    phase_d = ph1;
    xor_d   = xor1;
    digit_d = dig1;
    seen_d  = seen1;
    cnt_d   = cnt_q;
    baud_d  = baud_q;
    ok      = 1'b0;
    changed = 1'b0;
    if (in_i.chunk_end) begin
      ok = seen1 || (ph1 == PH_DIGIT && {4'd0, dig1} == xor1);
      phase_d = PH_IDLE;
      seen_d  = 1'b0;
      if (ok) begin
        cnt_d = cfg_i.ok_reload;
      end else if (cnt_dec == '0) begin
        baud_d  = (baud_q >= BaudLast) ? BaudFirst : baud_q + 3'd1;
        cnt_d   = cfg_i.fail_reload;
        changed = 1'b1;
      end else begin
        cnt_d = cnt_dec;
      end
    end
  end

  // result of this transaction
  always_comb begin
    res_o.chunk_ok      = ok;
    res_o.verdict_valid = in_i.chunk_end;
    res_o.baud_index    = baud_d;
    res_o.line_rate     = line_rate_of(baud_d);
    res_o.baud_changed  = changed;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      seen_q  <= 1'b0;
      cnt_q   <= CntReset;
      baud_q  <= BaudReset;
      xor_q   <= 8'd0;
      digit_q <= 4'd0;
    end else if (take_i) begin
      phase_q <= phase_d;
      seen_q  <= seen_d;
      cnt_q   <= cnt_d;
      baud_q  <= baud_d;
      xor_q   <= xor_d;
      digit_q <= digit_d;
    end
  end

endmodule

[rtl/nmea_checksum_autobaud_hunter.sv]
// ----------------------------------------------------------------------------
// nmea_checksum_autobaud_hunter
// Checks NMEA sentence checksums over read chunks and steps the baud
// selection when chunks keep failing.
// ----------------------------------------------------------------------------
//   channel | direction | handshake            | payload
//   in      | input     | in_valid_i/in_stall_o   | in_data_i  (nmeah_pkg::in_t)
//   out     | output    | out_valid_o/out_stall_i | out_data_o (nmeah_pkg::out_t)
//   cfg     | input     | cfg_we_i             | cfg_idx_i, cfg_data_i
//
// One transaction per cycle when not stalled; each produces exactly one
// result, registered on acceptance. The parser and countdown update in the
// same cycle the input is taken. A two-entry output stage (result register
// plus skid register) keeps in_stall_o registered; the input stalls only
// when both are full. Reset is asynchronous and clears all control state.
// ----------------------------------------------------------------------------
module nmea_checksum_autobaud_hunter (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  nmeah_pkg::in_t   in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output nmeah_pkg::out_t  out_data_o,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [11:0]      cfg_data_i
);
  import nmeah_pkg::*;

  cfg_t cfg_q;
  out_t res;
  out_t out_q, skid_q;
  logic out_valid_q, skid_valid_q;
  logic accept, out_take;

  assign in_stall_o  = skid_valid_q;
  assign accept      = in_valid_i && !skid_valid_q;
  assign out_take    = out_valid_q && !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  nmeah_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (accept),
    .in_i   (in_data_i),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fail_reload <= FailReloadReset;
      cfg_q.ok_reload   <= OkReloadReset;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_FAIL_RELOAD: cfg_q.fail_reload <= cfg_data_i;
        REG_OK_RELOAD:   cfg_q.ok_reload   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // output and skid valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_take) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= accept;
      end
    end else if (accept) begin
      if (out_valid_q) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end
  end

  // output and skid payload
  always_ff @(posedge clk_i) begin
    if (out_take) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (accept) begin
        out_q <= res;
      end
    end else if (accept) begin
      if (out_valid_q) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

endmodule

[sim/tb_nmea_checksum_autobaud_hunter.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_nmea_checksum_autobaud_hunter
// Feeds read chunks of serial bytes into the sentence checker: a few
// hand-built sentences first, then random chunks of well-formed and broken
// sentences, line noise and empty reads under four reload settings. A model
// of the parser and baud countdown predicts every verdict, and each result
// is compared field by field as it leaves the block. Both sides idle at
// random, and once the output is held off long enough to back up the input.
// ----------------------------------------------------------------------------
module tb_nmea_checksum_autobaud_hunter;
  import nmeah_pkg::*;

  // clock, reset and block ports
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall_o;
  in_t         in_data = '0;
  logic        out_valid_o;
  logic        out_stall = 1'b0;
  out_t        out_data_o;
  logic        cfg_we = 1'b0;
  reg_idx_e    cfg_idx = REG_FAIL_RELOAD;
  logic [11:0] cfg_data = '0;

  // stimulus and result bookkeeping
  in_t  rx_stream[$];
  out_t verdicts_due[$];
  out_t want_res;
  int   n_queued = 0;
  int   n_results = 0;
  int   n_chunks = 0;
  int   n_good = 0;
  int   n_steps = 0;
  int   errors = 0;
  bit   steady = 1'b0;
  bit   hold_req = 1'b0;
  bit   hold_done = 1'b0;
  int   hold_cnt = 0;

  // predictor state and its copy of the reload registers
  phase_e      prs_phase;
  logic [7:0]  run_xor;
  logic [3:0]  hi_nib;
  logic        got_good;
  logic [11:0] left_cnt;
  logic [2:0]  baud_sel;
  logic [11:0] fail_rel;
  logic [11:0] ok_rel;

  always #10 clk_i = ~clk_i;

  nmea_checksum_autobaud_hunter i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // hex digit decode, bit 4 flags a digit
  function automatic logic [4:0] nibble_of(logic [7:0] c);
    logic [7:0] low;
    low = c | 8'h20;
    if (c >= 8'h30 && c <= 8'h39) return {1'b1, c[3:0]};
    if (low >= 8'h61 && low <= 8'h66) return {1'b1, c[3:0] + 4'd9};
    return 5'h00;
  endfunction

  function automatic logic [16:0] rate_for(logic [2:0] sel);
    case (sel)
      3'd1, 3'd2, 3'd3, 3'd4: return 17'd4800 << (sel - 3'd1);
      3'd5: return 17'd57600;
      3'd6: return 17'd115200;
      default: return 17'd0;
    endcase
  endfunction

  // one transaction through the parser and the chunk-end countdown
  function automatic out_t predict_verdict(in_t it);
    out_t       r;
    logic [4:0] nib;
    logic [7:0] c;
    r = '0;
    c = it.rx_byte;
    nib = nibble_of(c);
    if (it.has_byte) begin
      case (prs_phase)
        PH_IDLE: begin
          if (c == CharDollar) begin
            prs_phase = PH_BODY;
            run_xor = '0;
          end
        end
        PH_BODY: begin
          if (c == 8'h00) prs_phase = PH_IDLE;
          else if (c == CharDollar) run_xor = '0;
          else if (c == CharStar) prs_phase = PH_STAR;
          else run_xor = run_xor ^ c;
        end
        PH_STAR: begin
          if (nib[4]) begin
            hi_nib = nib[3:0];
            prs_phase = PH_DIGIT;
          end else if (c == CharDollar) begin
            prs_phase = PH_BODY;
            run_xor = '0;
          end else if (!(c == 8'h20 || (c >= 8'h09 && c <= 8'h0d))) begin
            prs_phase = PH_IDLE;
          end
        end
        default: begin
          if (nib[4]) begin
            if ({hi_nib, nib[3:0]} == run_xor) got_good = 1'b1;
            prs_phase = PH_IDLE;
          end else begin
            // lone digit closed by a non-hex byte
            if ({4'h0, hi_nib} == run_xor) got_good = 1'b1;
            if (c == CharDollar) begin
              prs_phase = PH_BODY;
              run_xor = '0;
            end else begin
              prs_phase = PH_IDLE;
            end
          end
        end
      endcase
    end
    if (it.chunk_end) begin
      if (prs_phase == PH_DIGIT && {4'h0, hi_nib} == run_xor) got_good = 1'b1;
      prs_phase = PH_IDLE;
      r.verdict_valid = 1'b1;
      r.chunk_ok = got_good;
      got_good = 1'b0;
      if (r.chunk_ok) begin
        left_cnt = ok_rel;
      end else begin
        left_cnt = left_cnt - 12'd1;
        if (left_cnt == 12'd0) begin
          baud_sel = (baud_sel == BaudLast) ? BaudFirst : baud_sel + 3'd1;
          left_cnt = fail_rel;
          r.baud_changed = 1'b1;
        end
      end
    end
    r.baud_index = baud_sel;
    r.line_rate = rate_for(baud_sel);
    return r;
  endfunction

  function automatic bit idle_draw();
    return !steady && ($urandom_range(0, 99) < 31);
  endfunction

  task automatic push_item(logic [7:0] b, logic has, logic ends);
    in_t it;
    it.rx_byte = b;
    it.has_byte = has;
    it.chunk_end = ends;
    rx_stream.push_back(it);
    n_queued++;
  endtask

  task automatic push_text(string s, bit ends);
    for (int i = 0; i < s.len(); i++) push_item(s[i], 1'b1, ends && i == s.len() - 1);
  endtask

  function automatic logic [7:0] body_char();
    logic [7:0] c;
    do begin
      c = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255))
                                      : 8'($urandom_range(8'h20, 8'h7e));
    end while (c == CharDollar || c == CharStar);
    return c;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] v);
    if (v < 4'd10) return 8'h30 + v;
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + v - 8'd10;
  endfunction

  function automatic logic [7:0] space_char();
    case ($urandom_range(0, 5))
      0: return 8'h20;
      1: return 8'h09;
      2: return 8'h0a;
      3: return 8'h0b;
      4: return 8'h0c;
      default: return 8'h0d;
    endcase
  endfunction

  // one random read chunk: sentences, some broken, with noise and empty reads
  task automatic gen_chunk();
    logic [7:0] seq[$];
    logic [7:0] b;
    logic [7:0] sum;
    logic [7:0] csum;
    int         mut;
    int         cut;
    if ($urandom_range(0, 9) == 0) begin
      push_item(8'($urandom), 1'b0, 1'b1);
      return;
    end
    repeat ($urandom_range(1, 3)) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 4)) seq.push_back(8'($urandom));
      end else begin
        mut = $urandom_range(0, 9);
        sum = '0;
        seq.push_back(CharDollar);
        repeat ($urandom_range(0, 6)) begin
          b = body_char();
          seq.push_back(b);
          sum ^= b;
        end
        // broken forms: zero byte in the body, restart with a new dollar
        if (mut == 1) seq.push_back(8'h00);
        if (mut == 2) begin
          b = body_char();
          seq.push_back(CharDollar);
          seq.push_back(b);
          sum = b;
        end
        // steer toward a one-digit checksum now and then
        if ($urandom_range(0, 2) == 0) begin
          b = sum ^ 8'($urandom_range(0, 15));
          if (b != 8'h00 && b != CharDollar && b != CharStar) begin
            seq.push_back(b);
            sum ^= b;
          end
        end
        seq.push_back(CharStar);
        if (mut == 3) seq.push_back(8'h47);
        repeat ($urandom_range(0, 2)) seq.push_back(space_char());
        csum = (mut == 0) ? sum ^ (8'h01 << $urandom_range(0, 7)) : sum;
        if (csum < 8'd16 && $urandom_range(0, 1)) begin
          seq.push_back(hex_char(csum[3:0]));
          case ($urandom_range(0, 3))
            0: seq.push_back(CharCr);
            1: seq.push_back(8'h00);
            2: seq.push_back(CharDollar);
            default: ;
          endcase
        end else begin
          seq.push_back(hex_char(csum[7:4]));
          seq.push_back(hex_char(csum[3:0]));
        end
        if ($urandom_range(0, 1)) begin
          seq.push_back(CharCr);
          seq.push_back(8'h0a);
        end
      end
    end
    // cut the read short so a sentence straddles the chunk boundary
    if ($urandom_range(0, 7) == 0) begin
      cut = $urandom_range(1, seq.size());
      while (seq.size() > cut) void'(seq.pop_back());
    end
    foreach (seq[i]) begin
      if ($urandom_range(0, 11) == 0) push_item(8'($urandom), 1'b0, 1'b0);
      push_item(seq[i], 1'b1, i == seq.size() - 1);
    end
  endtask

  task automatic fill(int count);
    int goal;
    goal = n_queued + count;
    while (n_queued < goal) gen_chunk();
  endtask

  // block must be idle: nothing queued, offered or outstanding
  task automatic drain();
    while (rx_stream.size() != 0 || in_valid || verdicts_due.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [11:0] val);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == REG_FAIL_RELOAD) fail_rel = val;
    else ok_rel = val;
    @(negedge clk_i);
  endtask

  // input driver: offer the head of the stream, predict on acceptance
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall_o) begin
      if (in_valid) begin
        verdicts_due.push_back(predict_verdict(in_data));
        void'(rx_stream.pop_front());
      end
      if (rx_stream.size() != 0 && !idle_draw()) begin
        in_valid <= 1'b1;
        in_data <= rx_stream[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor and output stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall) begin
        n_results++;
        if (verdicts_due.size() == 0) begin
          $display("%0t: result with nothing pending: %p", $time, out_data_o);
          errors++;
        end else begin
          want_res = verdicts_due.pop_front();
          if (out_data_o.chunk_ok !== want_res.chunk_ok) begin
            $display("%0t: chunk_ok expected %0d got %0d", $time,
                     want_res.chunk_ok, out_data_o.chunk_ok);
            errors++;
          end
          if (out_data_o.verdict_valid !== want_res.verdict_valid) begin
            $display("%0t: verdict_valid expected %0d got %0d", $time,
                     want_res.verdict_valid, out_data_o.verdict_valid);
            errors++;
          end
          if (out_data_o.baud_index !== want_res.baud_index) begin
            $display("%0t: baud_index expected %0d got %0d", $time,
                     want_res.baud_index, out_data_o.baud_index);
            errors++;
          end
          if (out_data_o.line_rate !== want_res.line_rate) begin
            $display("%0t: line_rate expected %0d got %0d", $time,
                     want_res.line_rate, out_data_o.line_rate);
            errors++;
          end
          if (out_data_o.baud_changed !== want_res.baud_changed) begin
            $display("%0t: baud_changed expected %0d got %0d", $time,
                     want_res.baud_changed, out_data_o.baud_changed);
            errors++;
          end
          n_chunks += want_res.verdict_valid;
          n_good += want_res.chunk_ok;
          n_steps += want_res.baud_changed;
        end
      end
      // one long hold-off lets the output stage fill and stall the input
      if (hold_req && !hold_done) begin
        hold_done <= 1'b1;
        hold_cnt <= 400;
        out_stall <= 1'b1;
      end else if (hold_cnt != 0) begin
        hold_cnt <= hold_cnt - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= idle_draw();
      end
    end
  end

  // main sequence
  initial begin
    fail_rel = FailReloadReset;
    ok_rel = OkReloadReset;
    prs_phase = PH_IDLE;
    run_xor = '0;
    hi_nib = '0;
    got_good = 1'b0;
    left_cnt = CntReset;
    baud_sel = BaudReset;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: good sentence, whitespace and lone digit, restart, cases
    push_text("$A*41", 1'b1);
    push_item(CharDollar, 1'b1, 1'b0);
    push_item(8'h05, 1'b1, 1'b0);
    push_text("* 5", 1'b1);
    push_text("$x$j*6A", 1'b1);
    push_text("$j*6a", 1'b1);
    push_item(8'hff, 1'b0, 1'b1);
    push_text("$A", 1'b0);
    push_item(8'h00, 1'b1, 1'b0);
    push_text("*41", 1'b1);
    push_item(CharDollar, 1'b1, 1'b0);
    push_item(8'hff, 1'b1, 1'b0);
    push_text("*G", 1'b1);
    push_item(CharDollar, 1'b1, 1'b0);
    push_item(8'h07, 1'b1, 1'b0);
    push_text("*7$", 1'b1);
    drain();

    // quick stepping: short fail reload, minimal ok reload
    write_reg(REG_FAIL_RELOAD, 12'd3);
    write_reg(REG_OK_RELOAD, 12'd1);
    fill(450);
    drain();

    // fail reload of one steps on each failure until a good chunk reloads 4095; no idling in this stretch
    steady = 1'b1;
    write_reg(REG_FAIL_RELOAD, 12'd1);
    write_reg(REG_OK_RELOAD, 12'd4095);
    fill(350);
    drain();
    steady = 1'b0;

    write_reg(REG_FAIL_RELOAD, 12'd4095);
    write_reg(REG_OK_RELOAD, 12'd1);
    fill(300);
    drain();

    // random small reloads with a long output hold-off
    write_reg(REG_FAIL_RELOAD, 12'($urandom_range(1, 6)));
    write_reg(REG_OK_RELOAD, 12'($urandom_range(1, 12)));
    fill(725);
    hold_req = 1'b1;
    drain();
    repeat (5) @(posedge clk_i);

    $display("covered %0d transactions in %0d chunks: %0d good chunks, %0d baud steps",
             n_results, n_chunks, n_good, n_steps);
    $display("reload settings swept from 1 to 4095, %0d mismatches", errors);
    if (errors == 0) begin
      $display("tb_nmea_checksum_autobaud_hunter: PASS");
    end else begin
      $display("tb_nmea_checksum_autobaud_hunter: FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("tb_nmea_checksum_autobaud_hunter: FAIL");
    $finish;
  end

endmodule
